// File: design/kbps_pkg.sv
package kbps_pkg;

  localparam int unsigned SIDE_BITS = 4;
  localparam int unsigned CELL_BITS = 2 * SIDE_BITS;
  localparam int unsigned CELLS     = 1 << CELL_BITS;

  localparam logic [2:0] OP_BEGIN   = 3'd0;
  localparam logic [2:0] OP_KEY     = 3'd1;
  localparam logic [2:0] OP_FINISH  = 3'd2;
  localparam logic [2:0] OP_ENCRYPT = 3'd3;
  localparam logic [2:0] OP_DECRYPT = 3'd4;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_READY = 2'd1;
  localparam logic [1:0] STS_BAD_COORD = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic [7:0] col_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic                 clear;
    logic                 place;
    logic [7:0]           place_byte;
    logic                 rd;
    logic [CELL_BITS-1:0] rd_addr;
  } tbl_cmd_t;

  typedef struct packed {
    logic [CELL_BITS-1:0] b2c_q;
    logic [7:0]           c2b_q;
  } tbl_rsp_t;

  function automatic out_item_t mk_out(logic [7:0] b, logic [1:0] s, logic l);
    out_item_t o;
    o.out_byte = b;
    o.status   = s;
    o.last     = l;
    return o;
  endfunction

endpackage

// File: design/keyed_byte_polybius_square.sv
// channel   ports                              handshake
// input     start, busy, in_item               accepted when start && !busy
// result    out_valid, out_item                one cycle per result, no backpressure
//
// begin and key items give no result
// encrypt steps through a table read, a row byte and a column byte; decrypt through a table read and the byte
// finish that fills the square walks all 256 byte values, one per cycle
// errors and a finish that needs no fill give their result in the cycle after accept
// synchronous active-low reset clears the used bits, fill count and control state
// results cannot be stalled; the next item may be taken while a result is shown
module keyed_byte_polybius_square (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kbps_pkg::in_item_t  in_item,
  output logic                out_valid,
  output kbps_pkg::out_item_t out_item
);

  kbps_pkg::tbl_cmd_t cmd;
  kbps_pkg::tbl_rsp_t rsp;

  kbps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .cmd       (cmd),
    .rsp       (rsp),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  kbps_tables u_tables (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

endmodule

// File: design/kbps_tables.sv
module kbps_tables (
  input  logic             clk,
  input  logic             rst_n,
  input  kbps_pkg::tbl_cmd_t cmd,
  output kbps_pkg::tbl_rsp_t rsp
);

  logic [7:0]                     c2b_mem [kbps_pkg::CELLS];
  logic [kbps_pkg::CELL_BITS-1:0] b2c_mem [kbps_pkg::CELLS];
  logic [kbps_pkg::CELLS-1:0]     used_r;
  logic [kbps_pkg::CELL_BITS:0]   fill_r;
  logic                           do_place;

  // place a byte at the next free cell unless already used or the square is full
  assign do_place = cmd.place && !used_r[cmd.place_byte] && !fill_r[kbps_pkg::CELL_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      used_r <= '0;
      fill_r <= '0;
    end else if (do_place) begin
      used_r[cmd.place_byte] <= 1'b1;
      fill_r <= fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_place) begin
      c2b_mem[fill_r[kbps_pkg::CELL_BITS-1:0]] <= cmd.place_byte;
      b2c_mem[cmd.place_byte] <= fill_r[kbps_pkg::CELL_BITS-1:0];
    end
    if (cmd.rd) begin
      rsp.c2b_q <= c2b_mem[cmd.rd_addr];
      rsp.b2c_q <= b2c_mem[cmd.rd_addr];
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= kbps_pkg::CELLS)
    else $error("fill count past square size");

  a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_place && !cmd.clear |=> fill_r == $past(fill_r) + 1'b1)
    else $error("placed byte did not advance fill");

  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == fill_r)
    else $error("used bits disagree with fill count");

endmodule

// File: design/kbps_ctrl.sv
module kbps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  kbps_pkg::in_item_t  in_item,
  output logic                busy,
  output kbps_pkg::tbl_cmd_t  cmd,
  input  kbps_pkg::tbl_rsp_t  rsp,
  output logic                out_valid,
  output kbps_pkg::out_item_t out_item
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_FILL    = 3'd1;
  localparam logic [2:0] ST_ENC_RD  = 3'd2;
  localparam logic [2:0] ST_ENC_COL = 3'd3;
  localparam logic [2:0] ST_DEC_RD  = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [7:0]                     fill_v_r, fill_v_nxt;
  logic                           key_seen_r, key_seen_nxt;
  logic                           ready_r, ready_nxt;
  logic [kbps_pkg::SIDE_BITS-1:0] col_r, col_nxt;
  logic                           out_valid_r, out_valid_nxt;
  kbps_pkg::out_item_t            out_item_r, out_item_nxt;
  logic                           accept;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    fill_v_nxt    = fill_v_r;
    key_seen_nxt  = key_seen_r;
    ready_nxt     = ready_r;
    col_nxt       = col_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.operation)
            kbps_pkg::OP_BEGIN: begin
              cmd.clear    = 1'b1;
              key_seen_nxt = 1'b0;
              ready_nxt    = 1'b0;
            end
            kbps_pkg::OP_KEY: begin
              if (!ready_r) begin
                cmd.place      = 1'b1;
                cmd.place_byte = in_item.data_byte;
                key_seen_nxt   = 1'b1;
              end
            end
            kbps_pkg::OP_FINISH: begin
              if (ready_r) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = kbps_pkg::mk_out(8'd0, kbps_pkg::STS_OK, 1'b1);
              end else if (!key_seen_r) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = kbps_pkg::mk_out(8'd0, kbps_pkg::STS_NOT_READY, 1'b1);
              end else begin
                fill_v_nxt = '0;
                state_nxt  = ST_FILL;
              end
            end
            kbps_pkg::OP_ENCRYPT: begin
              if (!ready_r) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = kbps_pkg::mk_out(8'd0, kbps_pkg::STS_NOT_READY, 1'b1);
              end else begin
                cmd.rd      = 1'b1;
                cmd.rd_addr = in_item.data_byte;
                state_nxt   = ST_ENC_RD;
              end
            end
            kbps_pkg::OP_DECRYPT: begin
              if (!ready_r) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = kbps_pkg::mk_out(8'd0, kbps_pkg::STS_NOT_READY, 1'b1);
              end else if (in_item.data_byte[7:kbps_pkg::SIDE_BITS] != '0 ||
                           in_item.col_byte[7:kbps_pkg::SIDE_BITS] != '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = kbps_pkg::mk_out(8'd0, kbps_pkg::STS_BAD_COORD, 1'b1);
              end else begin
                cmd.rd      = 1'b1;
                cmd.rd_addr = {in_item.data_byte[kbps_pkg::SIDE_BITS-1:0],
                               in_item.col_byte[kbps_pkg::SIDE_BITS-1:0]};
                state_nxt   = ST_DEC_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd.place      = 1'b1;
        cmd.place_byte = fill_v_r;
        fill_v_nxt     = fill_v_r + 8'd1;
        if (fill_v_r == 8'hFF) begin
          ready_nxt     = 1'b1;
          out_valid_nxt = 1'b1;
          out_item_nxt  = kbps_pkg::mk_out(8'd0, kbps_pkg::STS_OK, 1'b1);
          state_nxt     = ST_IDLE;
        end
      end
      ST_ENC_RD: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = kbps_pkg::mk_out({4'd0, rsp.b2c_q[kbps_pkg::CELL_BITS-1:kbps_pkg::SIDE_BITS]},
                                         kbps_pkg::STS_OK, 1'b0);
        col_nxt       = rsp.b2c_q[kbps_pkg::SIDE_BITS-1:0];
        state_nxt     = ST_ENC_COL;
      end
      ST_ENC_COL: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = kbps_pkg::mk_out({4'd0, col_r}, kbps_pkg::STS_OK, 1'b1);
        state_nxt     = ST_IDLE;
      end
      ST_DEC_RD: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = kbps_pkg::mk_out(rsp.c2b_q, kbps_pkg::STS_OK, 1'b1);
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_v_r    <= '0;
      key_seen_r  <= 1'b0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_v_r    <= fill_v_nxt;
      key_seen_r  <= key_seen_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    out_item_r <= out_item_nxt;
  end

  a_col_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.last |=> out_valid_r && out_item_r.last)
    else $error("row byte not followed by column byte");

  a_quiet_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FILL |-> !out_valid_r)
    else $error("result during table fill");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status != kbps_pkg::STS_OK |->
      out_item_r.out_byte == 8'd0 && out_item_r.last)
    else $error("error result carries data");

  a_ready_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> key_seen_r)
    else $error("table ready without key");

endmodule
